### hdl/ebeq_pkg.sv
// Package for the encoder/button event qualifier.
// Field widths, event codes and register indexes; used by the interfaces and the top level.
`timescale 1ns / 1ps

package ebeq_pkg;

  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int STEPS_W  = 23;
  localparam int POS_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LONG_PRESS_W = 16;
  localparam int SETTLE_W     = 8;
  localparam int MULT_W       = 8;

  localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [SETTLE_W-1:0]     SETTLE_RST     = 8'd20;
  localparam logic [MULT_W-1:0]       MULT_RST       = 8'd20;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_CW   = 2'd1,
    ROT_CCW  = 2'd2
  } rot_t;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS  = 2'd0,
    CFG_BACK_SETTLE = 2'd1,
    CFG_JOG_MULT    = 2'd2
  } cfg_idx_t;

  // Signed divide by 2**sh truncating toward zero.
  function automatic logic signed [COUNT_W-1:0] trunc_div(
    input logic signed [COUNT_W-1:0] v,
    input int unsigned sh
  );
    logic signed [COUNT_W:0] adj;
    logic signed [COUNT_W:0] bias;
    begin
      bias = v[COUNT_W-1] ? ((17'sd1 <<< sh) - 17'sd1) : 17'sd0;
      adj  = {v[COUNT_W-1], v} + bias;
      trunc_div = COUNT_W'(adj >>> sh);
    end
  endfunction

endpackage

### hdl/ebeq_poll_if.sv
// Poll channel: valid/ready plus one poll word.
// Depends on ebeq_pkg.
`timescale 1ns / 1ps

interface ebeq_poll_if
  import ebeq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TIME_W-1:0]    now_ms;
  logic [COUNT_W-1:0]   encoder_count;
  logic                 wheel_pressed;
  logic                 back_level;
  logic                 jog_mode;

  modport source (output valid, now_ms, encoder_count, wheel_pressed, back_level,
                  jog_mode, input ready);
  modport sink   (input valid, now_ms, encoder_count, wheel_pressed, back_level,
                  jog_mode, output ready);
endinterface

### hdl/ebeq_event_if.sv
// Event channel: valid/ready plus one event word.
// Depends on ebeq_pkg.
`timescale 1ns / 1ps

interface ebeq_event_if
  import ebeq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           rotate_event;
  logic [1:0]           press_event;
  logic                 back_event;
  logic [STEPS_W-1:0]   jog_steps;
  logic                 jog_reverse;
  logic [POS_W-1:0]     position;

  modport source (output valid, rotate_event, press_event, back_event, jog_steps,
                  jog_reverse, position, input ready);
  modport sink   (input valid, rotate_event, press_event, back_event, jog_steps,
                  jog_reverse, position, output ready);
endinterface

### hdl/ebeq_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ebeq_pkg.
`timescale 1ns / 1ps

interface ebeq_cfg_if
  import ebeq_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/encoder_button_event_qualifier_unit.sv
// Encoder / button event qualifier: menu detents, jog steps, press and back events.
// Depends on ebeq_pkg, ebeq_poll_if, ebeq_event_if, ebeq_cfg_if.
//
//   port    dir   word                                   handshake
//   item    in    now_ms, encoder_count, buttons, jog    valid/ready
//   result  out   rotate/press/back events, jog, pos     valid/ready
//   cfg     in    index, data                            valid/ready
//
// One poll per cycle sustained unless the result stalls; result is registered.
// The poll sits in an input register; event state updates as it moves to the
// result register, so the next poll in the input register sees it.
// A stalled result holds both registers; the input side keeps taking one word
// while the input register is empty. Synchronous reset restores register defaults.
`timescale 1ns / 1ps

module encoder_button_event_qualifier_unit
  import ebeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ebeq_poll_if.sink   item,
  ebeq_event_if.source result,
  ebeq_cfg_if.sink    cfg
);

  logic [LONG_PRESS_W-1:0] long_press_ms;
  logic [SETTLE_W-1:0]     back_settle_ms;
  logic [MULT_W-1:0]       jog_multiplier;

  // input register
  logic                s1_valid;
  logic [TIME_W-1:0]   s1_now;
  logic [COUNT_W-1:0]  s1_count;
  logic                s1_wheel;
  logic                s1_back;
  logic                s1_jog;

  // event state
  logic [COUNT_W-1:0]  last_count;
  logic [TIME_W-1:0]   press_start;
  logic                press_active;
  logic                long_reported;
  logic                back_prev;
  logic                back_pending;
  logic [TIME_W-1:0]   back_due;
  logic [POS_W-1:0]    jog_position;
  logic                prev_jog_mode;

  logic                out_valid;
  logic                s1_adv;

  assign cfg.ready  = 1'b1;
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms  <= LONG_PRESS_RST;
      back_settle_ms <= SETTLE_RST;
      jog_multiplier <= MULT_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_LONG_PRESS:  long_press_ms  <= cfg.data[LONG_PRESS_W-1:0];
        CFG_BACK_SETTLE: back_settle_ms <= cfg.data[SETTLE_W-1:0];
        CFG_JOG_MULT:    jog_multiplier <= cfg.data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_now   <= item.now_ms;
      s1_count <= item.encoder_count;
      s1_wheel <= item.wheel_pressed;
      s1_back  <= item.back_level;
      s1_jog   <= item.jog_mode;
    end
  end

  // encoder
  logic signed [COUNT_W-1:0] q_new, q_old;
  logic signed [COUNT_W:0]   diff;
  logic [COUNT_W-1:0]        mag;
  logic [STEPS_W-1:0]        steps;
  logic                      moved;
  logic [1:0]                rot;
  logic                      rev;
  logic [COUNT_W-1:0]        last_count_next;
  logic [POS_W-1:0]          pos_base, jog_position_next;

  always_comb begin
    q_new = trunc_div(s1_count, s1_jog ? 1 : 2);
    q_old = trunc_div(last_count, s1_jog ? 1 : 2);
    diff  = {q_new[COUNT_W-1], q_new} - {q_old[COUNT_W-1], q_old};
    moved = (diff != '0);
    mag   = diff[COUNT_W] ? COUNT_W'(-diff) : COUNT_W'(diff);
    steps = (s1_jog && moved) ? STEPS_W'(mag[COUNT_W-2:0] * jog_multiplier) : '0;
    rev   = s1_jog && diff[COUNT_W] && (steps != '0);
    rot   = ROT_NONE;
    if (!s1_jog && moved) begin
      rot = diff[COUNT_W] ? ROT_CCW : ROT_CW;
    end
    last_count_next = moved ? s1_count : last_count;
    pos_base = (s1_jog && !prev_jog_mode) ? '0 : jog_position;
    if (!s1_jog) begin
      jog_position_next = pos_base;
    end else if (diff[COUNT_W]) begin
      jog_position_next = pos_base - POS_W'(steps);
    end else begin
      jog_position_next = pos_base + POS_W'(steps);
    end
  end

  // wheel button
  logic [TIME_W-1:0] elapsed;
  logic [1:0]        press;
  logic              press_active_next, long_reported_next;
  logic [TIME_W-1:0] press_start_next;

  always_comb begin
    elapsed = press_active ? (s1_now - press_start) : '0;
    press = PRESS_NONE;
    press_active_next  = press_active;
    long_reported_next = long_reported;
    press_start_next   = press_active ? press_start : s1_now;
    if (s1_wheel) begin
      press_active_next = 1'b1;
      if (elapsed > TIME_W'(long_press_ms) && !long_reported) begin
        press = PRESS_LONG;
        long_reported_next = 1'b1;
      end
    end else if (press_active) begin
      if (elapsed < TIME_W'(long_press_ms) && !long_reported) begin
        press = PRESS_SHORT;
      end
      press_active_next  = 1'b0;
      long_reported_next = 1'b0;
    end
  end

  // back button; on the edge poll the due time is reached only for zero settle
  logic              back_fall, back_fire, back_pending_next;
  logic [TIME_W-1:0] back_due_next, due_diff;

  always_comb begin
    back_fall     = !s1_back && back_prev;
    due_diff      = s1_now - back_due;
    back_due_next = back_fall ? (s1_now + TIME_W'(back_settle_ms)) : back_due;
    if (back_fall) begin
      back_fire = (back_settle_ms == '0);
    end else begin
      back_fire = back_pending && !due_diff[TIME_W-1];
    end
    back_pending_next = (back_fall || back_pending) && !back_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count    <= '0;
      press_start   <= '0;
      press_active  <= 1'b0;
      long_reported <= 1'b0;
      back_prev     <= 1'b1;
      back_pending  <= 1'b0;
      back_due      <= '0;
      jog_position  <= '0;
      prev_jog_mode <= 1'b0;
    end else if (s1_adv) begin
      last_count    <= last_count_next;
      press_start   <= press_start_next;
      press_active  <= press_active_next;
      long_reported <= long_reported_next;
      back_prev     <= s1_back;
      back_pending  <= back_pending_next;
      back_due      <= back_due_next;
      jog_position  <= jog_position_next;
      prev_jog_mode <= s1_jog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.rotate_event <= rot;
      result.press_event  <= press;
      result.back_event   <= back_fire && !s1_back;
      result.jog_steps    <= steps;
      result.jog_reverse  <= rev;
      result.position     <= jog_position_next;
    end
  end

  a_rot_no_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.rotate_event != ROT_NONE) |-> (result.jog_steps == '0))
    else $error("rotate event together with jog steps");

  a_rev_has_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.jog_reverse) |-> (result.jog_steps != '0))
    else $error("jog reverse without steps");

  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    long_reported |-> press_active)
    else $error("long press flagged without active press");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> ($stable(jog_position) && $stable(last_count)))
    else $error("event state moved while poll stalled");

endmodule

### bench/tb.sv
// Self-checking bench for encoder_button_event_qualifier_unit.
// Random and directed polls against a cycle-free event predictor; depends on ebeq_pkg and
// the poll, event and cfg interfaces.
`timescale 1ns / 1ps

module tb;
  import ebeq_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]  now;
    logic [COUNT_W-1:0] count;
    logic               wheel;
    logic               back;
    logic               jog;
  } poll_word_t;

  typedef struct packed {
    rot_t               rot;
    press_t             press;
    logic               back;
    logic [STEPS_W-1:0] steps;
    logic               rev;
    logic [POS_W-1:0]   pos;
  } event_word_t;

  logic clk;
  logic rst;

  ebeq_poll_if  item();
  ebeq_event_if result();
  ebeq_cfg_if   cfg();

  encoder_button_event_qualifier_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  poll_word_t  polls_pending[$];
  event_word_t events_due[$];
  int          mismatches = 0;
  int          polls_in = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  logic [LONG_PRESS_W-1:0] cfg_long   = LONG_PRESS_RST;
  logic [SETTLE_W-1:0]     cfg_settle = SETTLE_RST;
  logic [MULT_W-1:0]       cfg_mult   = MULT_RST;

  logic [COUNT_W-1:0] m_last_count;
  logic [TIME_W-1:0]  m_press_start;
  logic               m_press_active;
  logic               m_long_done;
  logic               m_back_prev;
  logic               m_back_pending;
  logic [TIME_W-1:0]  m_back_due;
  logic [POS_W-1:0]   m_jog_pos;
  logic               m_prev_jog;

  logic [TIME_W-1:0]  u_time;
  logic [COUNT_W-1:0] u_count;
  logic               u_wheel;
  logic               u_back;
  logic               u_jog;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic event_word_t qualify_poll(input poll_word_t p);
    event_word_t e;
    int          c;
    int          o;
    int          d;
    logic [31:0] mag;
    logic [31:0] steps;
    logic [31:0] elapsed;
    e.rot   = ROT_NONE;
    e.press = PRESS_NONE;
    e.back  = 1'b0;
    e.steps = '0;
    e.rev   = 1'b0;
    c = int'($signed(p.count));
    o = int'($signed(m_last_count));
    if (p.jog && !m_prev_jog) m_jog_pos = '0;
    m_prev_jog = p.jog;
    if (p.jog) begin
      d = c / 2 - o / 2;
      if (d != 0) begin
        mag = (d < 0) ? -d : d;
        steps = mag * 32'(cfg_mult);
        e.steps = steps[STEPS_W-1:0];
        if (d > 0) begin
          m_jog_pos = m_jog_pos + steps;
        end else begin
          m_jog_pos = m_jog_pos - steps;
          e.rev = (steps != 0);
        end
        m_last_count = p.count;
      end
    end else begin
      d = c / 4 - o / 4;
      if (d != 0) begin
        e.rot = (d > 0) ? ROT_CW : ROT_CCW;
        m_last_count = p.count;
      end
    end
    if (p.wheel) begin
      if (!m_press_active) begin
        m_press_active = 1'b1;
        m_press_start = p.now;
      end
      elapsed = p.now - m_press_start;
      if (elapsed > 32'(cfg_long) && !m_long_done) begin
        e.press = PRESS_LONG;
        m_long_done = 1'b1;
      end
    end else if (m_press_active) begin
      elapsed = p.now - m_press_start;
      if (elapsed < 32'(cfg_long) && !m_long_done) e.press = PRESS_SHORT;
      m_press_active = 1'b0;
      m_long_done = 1'b0;
    end
    if (!p.back && m_back_prev) begin
      m_back_pending = 1'b1;
      m_back_due = p.now + 32'(cfg_settle);
    end
    elapsed = p.now - m_back_due;
    if (m_back_pending && !elapsed[31]) begin
      m_back_pending = 1'b0;
      if (!p.back) e.back = 1'b1;
    end
    m_back_prev = p.back;
    e.pos = m_jog_pos;
    return e;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t ns: %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic push_poll(input logic [TIME_W-1:0] t, input logic [COUNT_W-1:0] c,
                           input logic w, input logic b, input logic j);
    poll_word_t p;
    p.now = t;
    p.count = c;
    p.wheel = w;
    p.back = b;
    p.jog = j;
    polls_pending.push_back(p);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_LONG_PRESS:  cfg_long = val;
      CFG_BACK_SETTLE: cfg_settle = val[SETTLE_W-1:0];
      CFG_JOG_MULT:    cfg_mult = val[MULT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (polls_pending.size() != 0 || item.valid || events_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly plausible user activity; a slice of fully random noise words.
  task automatic add_user_polls(input int n);
    int k;
    int s;
    int lim;
    int dt;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        push_poll($urandom, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        lim = int'(cfg_long);
        s = $urandom_range(0, 99);
        if (s < 55) dt = $urandom_range(0, 3);
        else if (s < 70) dt = $urandom_range(0, int'(cfg_settle) + 2);
        else if (s < 85) dt = $urandom_range(0, lim / 4 + 1);
        else if (s < 97) dt = $urandom_range((lim > 2) ? lim - 2 : 0, lim + 2);
        else dt = $urandom;
        u_time = u_time + 32'(dt);
        s = $urandom_range(0, 99);
        if (s < 50) u_count = u_count + 16'($urandom_range(0, 6)) - 16'd3;
        else if (s < 80) u_count = u_count + 16'($urandom_range(0, 18)) - 16'd9;
        else if (s > 90) u_count = 16'($urandom);
        if ($urandom_range(0, 9) == 0) u_wheel = ~u_wheel;
        if ($urandom_range(0, 7) == 0) u_back = ~u_back;
        if ($urandom_range(0, 49) == 0) u_jog = ~u_jog;
        push_poll(u_time, u_count, u_wheel, u_back, u_jog);
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_polls
    poll_word_t cur;
    logic       nv;
    int         burst_left;
    int         gap_left;
    if (rst) begin
      item.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      m_last_count = '0;
      m_press_start = '0;
      m_press_active = 1'b0;
      m_long_done = 1'b0;
      m_back_prev = 1'b1;
      m_back_pending = 1'b0;
      m_back_due = '0;
      m_jog_pos = '0;
      m_prev_jog = 1'b0;
    end else begin
      nv = item.valid;
      if (item.valid && item.ready) begin
        events_due.push_back(qualify_poll(cur));
        polls_in <= polls_in + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (polls_pending.size() > 0) begin
          cur = polls_pending.pop_front();
          nv = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      item.valid <= nv;
      if (nv) begin
        item.now_ms        <= cur.now;
        item.encoder_count <= cur.count;
        item.wheel_pressed <= cur.wheel;
        item.back_level    <= cur.back;
        item.jog_mode      <= cur.jog;
      end
    end
  end

  // One long receiver hold-off while polls keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && polls_in >= 1200) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : watch_events
    event_word_t want;
    logic        rdy;
    int          stall_mode;
    int          stall_cyc;
    if (rst) begin
      result.ready <= 1'b0;
      stall_mode = 0;
      stall_cyc = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (events_due.size() == 0) begin
          flag_mismatch("unexpected event word", 32'd0, 32'd0);
        end else begin
          want = events_due.pop_front();
          if (result.rotate_event !== want.rot)
            flag_mismatch("rotate_event", 32'(result.rotate_event), 32'(want.rot));
          if (result.press_event !== want.press)
            flag_mismatch("press_event", 32'(result.press_event), 32'(want.press));
          if (result.back_event !== want.back)
            flag_mismatch("back_event", 32'(result.back_event), 32'(want.back));
          if (result.jog_steps !== want.steps)
            flag_mismatch("jog_steps", 32'(result.jog_steps), 32'(want.steps));
          if (result.jog_reverse !== want.rev)
            flag_mismatch("jog_reverse", 32'(result.jog_reverse), 32'(want.rev));
          if (result.position !== want.pos)
            flag_mismatch("position", result.position, want.pos);
        end
      end
      if (stall_cyc == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cyc = $urandom_range(20, 80);
      end else begin
        stall_cyc--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (stall_cyc % 3 != 0);
      endcase
      if (hold_left != 0) rdy = 1'b0;
      result.ready <= rdy;
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item.valid = 1'b0;
    item.now_ms = '0;
    item.encoder_count = '0;
    item.wheel_pressed = 1'b0;
    item.back_level = 1'b1;
    item.jog_mode = 1'b0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_LONG_PRESS;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values: detents, truncation, jog entry, press limit, back settle, wrap
    push_poll(32'd1000, 16'd4, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1001, -16'sd4, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1002, -16'sd7, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1003, 16'sd32767, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1004, -16'sd32768, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1005, -16'sd32768, 1'b0, 1'b1, 1'b1);
    push_poll(32'd1006, 16'sd32767, 1'b0, 1'b1, 1'b1);
    push_poll(32'd1007, -16'sd32767, 1'b0, 1'b1, 1'b1);
    push_poll(32'd1008, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1009, 16'd0, 1'b0, 1'b1, 1'b1);
    push_poll(32'd2000, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd2800, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd2800, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd3000, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd3799, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd4000, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd4801, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd4802, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd5000, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd5019, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd5020, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd5030, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd5031, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd5032, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd5033, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd5053, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'hFFFF_FFF0, 16'd0, 1'b1, 1'b0, 1'b0);
    push_poll(32'h0000_0400, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'h0000_0401, 16'd0, 1'b0, 1'b1, 1'b0);
    u_time = 32'h0000_0401;
    u_count = '0;
    u_wheel = 1'b0;
    u_back = 1'b1;
    u_jog = 1'b0;
    add_user_polls(300);
    wait_idle();

    // low extremes
    set_reg(CFG_LONG_PRESS, 16'd1);
    set_reg(CFG_BACK_SETTLE, 16'd0);
    set_reg(CFG_JOG_MULT, 16'd1);
    push_poll(32'd100, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd101, 16'd0, 1'b0, 1'b0, 1'b0);
    push_poll(32'd102, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd200, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd201, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd202, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd203, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd300, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd300, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd400, 16'd0, 1'b1, 1'b1, 1'b0);
    push_poll(32'd401, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd500, 16'd0, 1'b0, 1'b1, 1'b1);
    push_poll(32'd501, 16'sd32767, 1'b0, 1'b1, 1'b1);
    push_poll(32'd502, -16'sd32768, 1'b0, 1'b1, 1'b1);
    push_poll(32'd503, 16'd0, 1'b0, 1'b1, 1'b0);
    u_time = 32'd503;
    u_count = '0;
    u_wheel = 1'b0;
    u_back = 1'b1;
    u_jog = 1'b0;
    add_user_polls(300);
    wait_idle();

    // high extremes
    set_reg(CFG_LONG_PRESS, 16'd65535);
    set_reg(CFG_BACK_SETTLE, 16'd255);
    set_reg(CFG_JOG_MULT, 16'd255);
    push_poll(32'd1000, 16'd0, 1'b0, 1'b1, 1'b0);
    push_poll(32'd1001, -16'sd32768, 1'b0, 1'b1, 1'b1);
    push_poll(32'd1002, 16'sd32767, 1'b0, 1'b1, 1'b1);
    push_poll(32'd1003, -16'sd32768, 1'b0, 1'b1, 1'b1);
    push_poll(32'd2000, -16'sd32768, 1'b1, 1'b1, 1'b1);
    push_poll(32'd67535, -16'sd32768, 1'b1, 1'b1, 1'b1);
    push_poll(32'd67536, -16'sd32768, 1'b1, 1'b1, 1'b1);
    push_poll(32'd67537, -16'sd32768, 1'b0, 1'b1, 1'b1);
    push_poll(32'd70000, -16'sd32768, 1'b0, 1'b0, 1'b1);
    push_poll(32'd70254, -16'sd32768, 1'b0, 1'b0, 1'b1);
    push_poll(32'd70255, -16'sd32768, 1'b0, 1'b0, 1'b1);
    push_poll(32'd70256, 16'd0, 1'b0, 1'b1, 1'b0);
    u_time = 32'd70256;
    u_count = '0;
    u_wheel = 1'b0;
    u_back = 1'b1;
    u_jog = 1'b0;
    add_user_polls(300);
    wait_idle();

    // short limits so the boundary cases come up often
    set_reg(CFG_LONG_PRESS, 16'($urandom_range(2, 20)));
    set_reg(CFG_BACK_SETTLE, 16'($urandom_range(0, 10)));
    set_reg(CFG_JOG_MULT, 16'($urandom_range(1, 255)));
    add_user_polls(400);
    wait_idle();

    set_reg(CFG_LONG_PRESS, 16'($urandom_range(1, 65535)));
    set_reg(CFG_BACK_SETTLE, 16'($urandom_range(0, 255)));
    set_reg(CFG_JOG_MULT, 16'($urandom_range(1, 255)));
    add_user_polls(300);
    wait_idle();

    set_reg(CFG_LONG_PRESS, 16'd3);
    set_reg(CFG_BACK_SETTLE, 16'd2);
    set_reg(CFG_JOG_MULT, 16'd7);
    add_user_polls(400);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
